@@ rtl/adb_pkg.sv @@
// Shared types and constants for the anti-aliased disc blend pipeline.
// Used by every module under rtl/; depends on nothing.
package adb_pkg;

   // Fixed-point format of the disc geometry
   localparam int FRAC_BITS   = 8;
   localparam int COORD_BITS  = 12;
   localparam int RADIUS_BITS = 16;

   // Field widths fixed by the interface
   localparam int CHAN_BITS   = 8;
   localparam int MARGIN_BITS = 5;
   localparam int FRAME_BITS  = 13;

   // Derived datapath widths
   localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
   localparam int PROD_BITS  = 2 * POS_BITS;
   localparam int SQ_BITS    = PROD_BITS + 1;
   localparam int ROOT_BITS  = POS_BITS + 1;
   localparam int WORK_BITS  = SQ_BITS + 1;
   localparam int WIDE_BITS  = ((POS_BITS > RADIUS_BITS) ? POS_BITS : RADIUS_BITS) + 2;
   localparam int EDGE_BITS  = WIDE_BITS - FRAC_BITS;
   localparam int CMP_BITS   = ((EDGE_BITS > FRAME_BITS + 1) ? EDGE_BITS : FRAME_BITS + 1);
   localparam int LIM_BITS   = ((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS);
   localparam int DIFF_BITS  = ((ROOT_BITS > RADIUS_BITS) ? ROOT_BITS : RADIUS_BITS);
   localparam int BLEND_BITS = 2 * CHAN_BITS + 1;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  =
      ((POS_BITS > RADIUS_BITS) ? POS_BITS : RADIUS_BITS) > FRAME_BITS ?
      ((POS_BITS > RADIUS_BITS) ? POS_BITS : RADIUS_BITS) : FRAME_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPOT_ALPHA   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLUR_MARGIN  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 3'd6;

   typedef logic [POS_BITS-1:0]         pos_type;
   typedef logic [PROD_BITS-1:0]        prod_type;
   typedef logic [SQ_BITS-1:0]          sq_type;
   typedef logic [ROOT_BITS-1:0]        root_type;
   typedef logic signed [EDGE_BITS-1:0] edge_type;
   typedef logic [FRAME_BITS-1:0]       frame_type;
   typedef logic [COORD_BITS-1:0]       coord_type;
   typedef logic [CHAN_BITS-1:0]        chan_type;
   typedef logic [RADIUS_BITS-1:0]      radius_type;
   typedef logic [MARGIN_BITS-1:0]      margin_type;

   // Full-scale channel value
   localparam chan_type FULL = '1;

   // Reset frame size
   localparam frame_type FRAME_WIDTH_RESET  = FRAME_BITS'(1280);
   localparam frame_type FRAME_HEIGHT_RESET = FRAME_BITS'(720);

   typedef struct packed {
      pos_type    center_x;
      pos_type    center_y;
      radius_type radius;
      chan_type   spot_alpha;
      margin_type blur_margin;
      frame_type  frame_width;
      frame_type  frame_height;
   } cfg_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      chan_type  bg_red;
      chan_type  bg_green;
      chan_type  bg_blue;
   } req_type;

   typedef struct packed {
      chan_type out_red;
      chan_type out_green;
      chan_type out_blue;
      chan_type coverage;
      logic     in_box;
   } rsp_type;

   // Per-item data carried alongside the distance datapath
   typedef struct packed {
      logic     in_box;
      chan_type bg_red;
      chan_type bg_green;
      chan_type bg_blue;
   } side_type;

endpackage

@@ rtl/adb_front.sv @@
// Front end: disc box per axis, pixel box test and squared distance to the center.
// Three register stages, all advancing on the shared enable; uses adb_pkg.
module adb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  adb_pkg::req_type  req,
   input  adb_pkg::cfg_type  cfg,
   output logic              out_valid,
   output adb_pkg::sq_type   out_sq,
   output adb_pkg::side_type out_side
);

   // Clamp a signed box edge to [0, size]
   function automatic adb_pkg::frame_type clamp_edge(input adb_pkg::edge_type e,
                                                     input adb_pkg::frame_type s);
      logic signed [adb_pkg::CMP_BITS-1:0] e_w;
      logic signed [adb_pkg::CMP_BITS-1:0] s_w;
      adb_pkg::frame_type                  res;
      e_w = adb_pkg::CMP_BITS'(e);
      s_w = adb_pkg::CMP_BITS'(s);
      if (e_w < 0) begin
         res = '0;
      end else if (e_w > s_w) begin
         res = s;
      end else begin
         res = e_w[adb_pkg::FRAME_BITS-1:0];
      end
      return res;
   endfunction

   // Widen the clamped box by the margin, clipped to [0, size]
   function automatic adb_pkg::frame_type widen_lo(input adb_pkg::frame_type a,
                                                   input adb_pkg::margin_type m);
      adb_pkg::frame_type m_w;
      m_w = adb_pkg::FRAME_BITS'(m);
      return (a >= m_w) ? a - m_w : '0;
   endfunction

   function automatic adb_pkg::frame_type widen_hi(input adb_pkg::frame_type b,
                                                   input adb_pkg::margin_type m,
                                                   input adb_pkg::frame_type s);
      logic [adb_pkg::FRAME_BITS:0] sum;
      sum = (adb_pkg::FRAME_BITS + 1)'(b) + (adb_pkg::FRAME_BITS + 1)'(m);
      return (sum > (adb_pkg::FRAME_BITS + 1)'(s)) ? s : sum[adb_pkg::FRAME_BITS-1:0];
   endfunction

   // ---------------- stage 1: capture, offsets, raw box edges
   logic                      v1_ff;
   adb_pkg::req_type          req1_ff;
   adb_pkg::pos_type          adx1_ff, ady1_ff, adx1_in, ady1_in;
   adb_pkg::edge_type         xlo1_ff, xhi1_ff, ylo1_ff, yhi1_ff;
   adb_pkg::edge_type         xlo1_in, xhi1_in, ylo1_in, yhi1_in;
   adb_pkg::pos_type          px_fix, py_fix;
   logic signed [adb_pkg::WIDE_BITS-1:0] xlo_sum, xhi_sum, ylo_sum, yhi_sum;

   always_comb begin
      px_fix  = adb_pkg::POS_BITS'(req.pixel_x) << adb_pkg::FRAC_BITS;
      py_fix  = adb_pkg::POS_BITS'(req.pixel_y) << adb_pkg::FRAC_BITS;
      adx1_in = (cfg.center_x >= px_fix) ? cfg.center_x - px_fix : px_fix - cfg.center_x;
      ady1_in = (cfg.center_y >= py_fix) ? cfg.center_y - py_fix : py_fix - cfg.center_y;
      // floor(c - r) and ceil(c + r) in whole pixels
      xlo_sum = adb_pkg::WIDE_BITS'(cfg.center_x) - adb_pkg::WIDE_BITS'(cfg.radius);
      ylo_sum = adb_pkg::WIDE_BITS'(cfg.center_y) - adb_pkg::WIDE_BITS'(cfg.radius);
      xhi_sum = adb_pkg::WIDE_BITS'(cfg.center_x) + adb_pkg::WIDE_BITS'(cfg.radius)
              + adb_pkg::WIDE_BITS'((1 << adb_pkg::FRAC_BITS) - 1);
      yhi_sum = adb_pkg::WIDE_BITS'(cfg.center_y) + adb_pkg::WIDE_BITS'(cfg.radius)
              + adb_pkg::WIDE_BITS'((1 << adb_pkg::FRAC_BITS) - 1);
      xlo1_in = xlo_sum[adb_pkg::WIDE_BITS-1:adb_pkg::FRAC_BITS];
      xhi1_in = xhi_sum[adb_pkg::WIDE_BITS-1:adb_pkg::FRAC_BITS];
      ylo1_in = ylo_sum[adb_pkg::WIDE_BITS-1:adb_pkg::FRAC_BITS];
      yhi1_in = yhi_sum[adb_pkg::WIDE_BITS-1:adb_pkg::FRAC_BITS];
   end

   // ---------------- stage 2: squares, clipped and widened box
   logic                 v2_ff;
   adb_pkg::req_type     req2_ff;
   adb_pkg::prod_type    sqx2_ff, sqy2_ff, sqx2_in, sqy2_in;
   adb_pkg::frame_type   xlo2_ff, xhi2_ff, ylo2_ff, yhi2_ff;
   adb_pkg::frame_type   xlo2_in, xhi2_in, ylo2_in, yhi2_in;
   logic                 ne2_ff, ne2_in;
   adb_pkg::frame_type   xa, xb, ya, yb;

   always_comb begin
      sqx2_in = adb_pkg::PROD_BITS'(adx1_ff) * adb_pkg::PROD_BITS'(adx1_ff);
      sqy2_in = adb_pkg::PROD_BITS'(ady1_ff) * adb_pkg::PROD_BITS'(ady1_ff);
      xa      = clamp_edge(xlo1_ff, cfg.frame_width);
      xb      = clamp_edge(xhi1_ff, cfg.frame_width);
      ya      = clamp_edge(ylo1_ff, cfg.frame_height);
      yb      = clamp_edge(yhi1_ff, cfg.frame_height);
      // an empty disc box touches nothing, whatever the margin
      ne2_in  = (xa != xb) && (ya != yb);
      xlo2_in = widen_lo(xa, cfg.blur_margin);
      ylo2_in = widen_lo(ya, cfg.blur_margin);
      xhi2_in = widen_hi(xb, cfg.blur_margin, cfg.frame_width);
      yhi2_in = widen_hi(yb, cfg.blur_margin, cfg.frame_height);
   end

   // ---------------- stage 3: distance squared, box test
   logic                 v3_ff;
   adb_pkg::sq_type      sq3_ff, sq3_in;
   adb_pkg::side_type    side3_ff, side3_in;
   logic [adb_pkg::LIM_BITS-1:0] px_w, py_w;

   always_comb begin
      px_w    = adb_pkg::LIM_BITS'(req2_ff.pixel_x);
      py_w    = adb_pkg::LIM_BITS'(req2_ff.pixel_y);
      sq3_in  = adb_pkg::SQ_BITS'(sqx2_ff) + adb_pkg::SQ_BITS'(sqy2_ff);
      side3_in.in_box   = ne2_ff
                        && (px_w >= adb_pkg::LIM_BITS'(xlo2_ff))
                        && (px_w <  adb_pkg::LIM_BITS'(xhi2_ff))
                        && (py_w >= adb_pkg::LIM_BITS'(ylo2_ff))
                        && (py_w <  adb_pkg::LIM_BITS'(yhi2_ff));
      side3_in.bg_red   = req2_ff.bg_red;
      side3_in.bg_green = req2_ff.bg_green;
      side3_in.bg_blue  = req2_ff.bg_blue;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         req1_ff  <= req;
         adx1_ff  <= adx1_in;
         ady1_ff  <= ady1_in;
         xlo1_ff  <= xlo1_in;
         xhi1_ff  <= xhi1_in;
         ylo1_ff  <= ylo1_in;
         yhi1_ff  <= yhi1_in;
         req2_ff  <= req1_ff;
         sqx2_ff  <= sqx2_in;
         sqy2_ff  <= sqy2_in;
         xlo2_ff  <= xlo2_in;
         xhi2_ff  <= xhi2_in;
         ylo2_ff  <= ylo2_in;
         yhi2_ff  <= yhi2_in;
         ne2_ff   <= ne2_in;
         sq3_ff   <= sq3_in;
         side3_ff <= side3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_sq    = sq3_ff;
   assign out_side  = side3_ff;

endmodule

@@ rtl/adb_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Carries the item's side data alongside; uses adb_pkg.
module adb_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  adb_pkg::sq_type   in_sq,
   input  adb_pkg::side_type in_side,
   output logic              out_valid,
   output adb_pkg::root_type out_root,
   output adb_pkg::side_type out_side
);

   localparam int STEPS = adb_pkg::ROOT_BITS;
   localparam int W     = adb_pkg::WORK_BITS;

   logic [W-1:0]      rem_ff   [STEPS-1];
   logic [W-1:0]      root_ff  [STEPS];
   logic              valid_ff [STEPS];
   adb_pkg::side_type side_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [W-1:0] STEP_BIT = W'(1) << (2 * (STEPS - 1 - k));

      logic [W-1:0]      rem_prev, root_prev, trial, rem_in, root_in;
      logic              valid_prev;
      adb_pkg::side_type side_prev;

      if (k == 0) begin : g_first
         assign rem_prev   = W'(in_sq);
         assign root_prev  = '0;
         assign valid_prev = in_valid;
         assign side_prev  = in_side;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign valid_prev = valid_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // Try the next root bit; keep it when the remainder allows
      always_comb begin
         trial = root_prev + STEP_BIT;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = (root_prev >> 1) + STEP_BIT;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end

      // The last step leaves no remainder to keep
      if (k < STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1][adb_pkg::ROOT_BITS-1:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

@@ rtl/adb_shade.sv @@
// Shading back end: edge coverage, spot alpha scaling and white blend.
// Three register stages on the shared enable; uses adb_pkg.
module adb_shade (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  adb_pkg::root_type in_root,
   input  adb_pkg::side_type in_side,
   input  adb_pkg::cfg_type  cfg,
   output logic              out_valid,
   output adb_pkg::rsp_type  out_rsp
);

   // (255 * a + bg * (255 - a)) >> 8
   function automatic adb_pkg::chan_type blend(input adb_pkg::chan_type bg,
                                               input adb_pkg::chan_type a);
      logic [adb_pkg::BLEND_BITS-1:0] sum;
      sum = adb_pkg::BLEND_BITS'(adb_pkg::FULL) * adb_pkg::BLEND_BITS'(a)
          + adb_pkg::BLEND_BITS'(bg) * adb_pkg::BLEND_BITS'(adb_pkg::FULL - a);
      return sum[2*adb_pkg::CHAN_BITS-1:adb_pkg::CHAN_BITS];
   endfunction

   // ---------------- stage 1: coverage from radius minus distance
   logic                 v1_ff;
   adb_pkg::chan_type    cov1_ff, cov1_in;
   adb_pkg::side_type    side1_ff;
   logic [adb_pkg::DIFF_BITS-1:0] rad_w, root_w, diff;
   logic [adb_pkg::FRAC_BITS-1:0] frac;
   logic [adb_pkg::FRAC_BITS+adb_pkg::CHAN_BITS-1:0] ramp;

   always_comb begin
      rad_w  = adb_pkg::DIFF_BITS'(cfg.radius);
      root_w = adb_pkg::DIFF_BITS'(in_root);
      diff   = rad_w - root_w;
      frac   = diff[adb_pkg::FRAC_BITS-1:0];
      // frac * 255 as frac * 256 - frac
      ramp   = {frac, adb_pkg::CHAN_BITS'(0)}
             - (adb_pkg::FRAC_BITS + adb_pkg::CHAN_BITS)'(frac);
      if (!in_side.in_box || root_w >= rad_w) begin
         cov1_in = '0;
      end else if (diff[adb_pkg::DIFF_BITS-1:adb_pkg::FRAC_BITS] == '0) begin
         cov1_in = ramp[adb_pkg::FRAC_BITS+adb_pkg::CHAN_BITS-1:adb_pkg::FRAC_BITS];
      end else begin
         cov1_in = adb_pkg::FULL;
      end
   end

   // ---------------- stage 2: opacity
   logic                 v2_ff;
   adb_pkg::chan_type    cov2_ff, alpha2_ff, alpha2_in;
   adb_pkg::side_type    side2_ff;
   logic [2*adb_pkg::CHAN_BITS-1:0] alpha_prod;

   always_comb begin
      alpha_prod = (2 * adb_pkg::CHAN_BITS)'(cov1_ff)
                 * (2 * adb_pkg::CHAN_BITS)'(cfg.spot_alpha);
      alpha2_in  = alpha_prod[2*adb_pkg::CHAN_BITS-1:adb_pkg::CHAN_BITS];
   end

   // ---------------- stage 3: blend or pass the background
   logic                 v3_ff;
   adb_pkg::rsp_type     rsp3_ff, rsp3_in;

   always_comb begin
      rsp3_in.coverage = cov2_ff;
      rsp3_in.in_box   = side2_ff.in_box;
      if (side2_ff.in_box) begin
         rsp3_in.out_red   = blend(side2_ff.bg_red, alpha2_ff);
         rsp3_in.out_green = blend(side2_ff.bg_green, alpha2_ff);
         rsp3_in.out_blue  = blend(side2_ff.bg_blue, alpha2_ff);
      end else begin
         rsp3_in.out_red   = side2_ff.bg_red;
         rsp3_in.out_green = side2_ff.bg_green;
         rsp3_in.out_blue  = side2_ff.bg_blue;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         cov1_ff   <= cov1_in;
         side1_ff  <= in_side;
         cov2_ff   <= cov1_ff;
         alpha2_ff <= alpha2_in;
         side2_ff  <= side1_ff;
         rsp3_ff   <= rsp3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_rsp   = rsp3_ff;

endmodule

@@ rtl/antialiased_disc_blend_top.sv @@
// Anti-aliased disc coverage and white blend, one pixel item per clock unless stalled.
// The block accepts one pixel item per cycle while req_ready is high. Each item passes
// three front-end stages (box, squares, sum), the square root, which resolves one
// distance bit per register stage (21 stages), three shading stages (coverage, alpha,
// blend) and the output register. All stages advance together; an output register with
// a one-item skid stage lets the pipeline keep taking items while a result waits, and
// req_ready drops only once the skid stage is occupied. Configuration writes are taken
// every cycle (csr_ready is always high) and must only be issued while no item is in
// flight. Uses adb_pkg, adb_front, adb_isqrt and adb_shade.
module antialiased_disc_blend_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  adb_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output adb_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [adb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [adb_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   // ---------------- configuration registers
   adb_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x     <= '0;
         cfg_ff.center_y     <= '0;
         cfg_ff.radius       <= '0;
         cfg_ff.spot_alpha   <= '0;
         cfg_ff.blur_margin  <= '0;
         cfg_ff.frame_width  <= adb_pkg::FRAME_WIDTH_RESET;
         cfg_ff.frame_height <= adb_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            adb_pkg::CSR_CENTER_X: begin
               cfg_ff.center_x <= csr_data[adb_pkg::POS_BITS-1:0];
            end
            adb_pkg::CSR_CENTER_Y: begin
               cfg_ff.center_y <= csr_data[adb_pkg::POS_BITS-1:0];
            end
            adb_pkg::CSR_RADIUS: begin
               cfg_ff.radius <= csr_data[adb_pkg::RADIUS_BITS-1:0];
            end
            adb_pkg::CSR_SPOT_ALPHA: begin
               cfg_ff.spot_alpha <= csr_data[adb_pkg::CHAN_BITS-1:0];
            end
            adb_pkg::CSR_BLUR_MARGIN: begin
               cfg_ff.blur_margin <= csr_data[adb_pkg::MARGIN_BITS-1:0];
            end
            adb_pkg::CSR_FRAME_WIDTH: begin
               cfg_ff.frame_width <= csr_data[adb_pkg::FRAME_BITS-1:0];
            end
            adb_pkg::CSR_FRAME_HEIGHT: begin
               cfg_ff.frame_height <= csr_data[adb_pkg::FRAME_BITS-1:0];
            end
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   // ---------------- pipeline
   logic              en;
   logic              front_valid, root_valid, shade_valid;
   adb_pkg::sq_type   front_sq;
   adb_pkg::side_type front_side, root_side;
   adb_pkg::root_type root_val;
   adb_pkg::rsp_type  shade_rsp;

   logic              out_valid_ff, skid_valid_ff;
   adb_pkg::rsp_type  out_data_ff, skid_data_ff;
   logic              emit, take;

   // Hold the whole pipeline while the skid stage is occupied
   assign en        = !skid_valid_ff;
   assign req_ready = en;

   adb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .req       (req_data),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_sq    (front_sq),
      .out_side  (front_side)
   );

   adb_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_sq     (front_sq),
      .in_side   (front_side),
      .out_valid (root_valid),
      .out_root  (root_val),
      .out_side  (root_side)
   );

   adb_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .in_root   (root_val),
      .in_side   (root_side),
      .cfg       (cfg_ff),
      .out_valid (shade_valid),
      .out_rsp   (shade_rsp)
   );

   // ---------------- output register and skid stage
   assign emit = en && shade_valid;
   assign take = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= emit;
         end
      end else if (emit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : shade_rsp;
      end
      if (!take && emit) begin
         skid_data_ff <= shade_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
